[design/spk_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// spk_pkg
// Shared constants and types for the spike key row address lookup.
// ============================================================================
package spk_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 32;
    localparam int NEURON_W      = 10;
    localparam int ENTRY_W       = 16;
    localparam int SIZE_W        = 3;
    localparam int OFFSET_W      = ENTRY_W - SIZE_W;
    localparam int BYTES_W       = 16;
    localparam int ADDR_W        = 32;
    localparam int PROD_W        = NEURON_W + BYTES_W;
    localparam int NUM_SIZES     = 1 << SIZE_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int KB_SHIFT      = 10;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_MISS  = 2'd2
    } spk_status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_BASE = 3'd0;

    typedef struct packed {
        logic [ADDR_W-1:0]                   matrix_base;
        logic [NUM_SIZES-1:0][BYTES_W-1:0]   row_bytes;
    } spk_cfg_t;

    typedef struct packed {
        logic               lookup;
        logic               out_of_range;
        logic [NEURON_W-1:0] neuron;
    } spk_req_t;

endpackage

[design/spk_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// spk_cfg_regs
// Matrix base and row size registers behind the configuration write channel.
// ============================================================================
module spk_cfg_regs
    import spk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output spk_cfg_t              cfg
);

    logic [ADDR_W-1:0]                 base_reg;
    logic [NUM_SIZES-1:0][BYTES_W-1:0] bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            bytes_reg <= '0;
        end else if (wr_en) begin
            if (wr_index == CFG_MATRIX_BASE) begin
                base_reg <= wr_data[ADDR_W-1:0];
            end else begin
                bytes_reg[wr_index] <= wr_data[BYTES_W-1:0];
            end
        end
    end

    assign cfg.matrix_base = base_reg;
    assign cfg.row_bytes   = bytes_reg;

endmodule

[design/spk_pop_table.sv]
`timescale 1ns / 1ps
// ============================================================================
// spk_pop_table
// Population table RAM, one write and one registered read port, with a
// clearing sweep after reset.
// ============================================================================
module spk_pop_table
    import spk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [TABLE_AW-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]  wr_data,
    input  logic                rd_en,
    input  logic [TABLE_AW-1:0] rd_addr,
    output logic [ENTRY_W-1:0]  rd_data,
    output logic                busy
);

    logic [ENTRY_W-1:0]  mem [TABLE_ENTRIES];
    logic [TABLE_AW:0]   clr_cnt_reg;
    logic                clearing_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (TABLE_AW+1)'(TABLE_ENTRIES - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg[TABLE_AW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

[design/spk_row_calc.sv]
`timescale 1ns / 1ps
// ============================================================================
// spk_row_calc
// Decodes a table entry, selects the row size and registers the neuron
// product, the base plus offset term, the row bytes and the status.
// ============================================================================
module spk_row_calc
    import spk_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  spk_req_t           req,
    input  logic [ENTRY_W-1:0] entry,
    input  spk_cfg_t           cfg,
    output spk_status_t        status,
    output logic [ADDR_W-1:0]  base_sum,
    output logic [PROD_W-1:0]  prod,
    output logic [BYTES_W-1:0] row_bytes
);

    logic [SIZE_W-1:0]   size_idx;
    logic [OFFSET_W-1:0] offset_kb;
    logic [BYTES_W-1:0]  sel_bytes;
    logic                hit;

    spk_status_t         status_reg;
    logic [ADDR_W-1:0]   base_sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [BYTES_W-1:0]  bytes_reg;

    assign size_idx  = entry[SIZE_W-1:0];
    assign offset_kb = entry[ENTRY_W-1:SIZE_W];
    assign sel_bytes = cfg.row_bytes[size_idx];
    assign hit       = req.lookup && !req.out_of_range && (size_idx != '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!req.lookup) begin
                status_reg <= STAT_OK;
            end else if (req.out_of_range) begin
                status_reg <= STAT_RANGE;
            end else if (size_idx == '0) begin
                status_reg <= STAT_MISS;
            end else begin
                status_reg <= STAT_OK;
            end
            if (hit) begin
                prod_reg     <= PROD_W'(req.neuron) * PROD_W'(sel_bytes);
                base_sum_reg <= cfg.matrix_base
                                + {{(ADDR_W-OFFSET_W-KB_SHIFT){1'b0}}, offset_kb,
                                   {KB_SHIFT{1'b0}}};
                bytes_reg    <= sel_bytes;
            end else begin
                prod_reg     <= '0;
                base_sum_reg <= '0;
                bytes_reg    <= '0;
            end
        end
    end

    assign status    = status_reg;
    assign base_sum  = base_sum_reg;
    assign prod      = prod_reg;
    assign row_bytes = bytes_reg;

endmodule

[design/spike_key_row_address_lookup.sv]
`timescale 1ns / 1ps
// ============================================================================
// spike_key_row_address_lookup
// Maps a spike key to a synaptic row address through the population table.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    op, key, table_index, table_entry
//  m_       out  m_valid/m_ready    status, row_address, row_bytes
//  cfg_     in   cfg_valid/cfg_ready index, data
//
//  Each item passes through table RAM read, multiply, final add.
//  Reset starts a clear of all 1024 table entries; s_ready stays low meanwhile.
//  The result register lets the next item enter while a result waits;
//  a stalled m_ channel holds the last stage until the result register frees.
// ============================================================================
module spike_key_row_address_lookup
    import spk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [TABLE_AW-1:0]   s_table_index,
    input  logic [ENTRY_W-1:0]    s_table_entry,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [ADDR_W-1:0]     m_row_address,
    output logic [BYTES_W-1:0]    m_row_bytes,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM
    } state_t;

    state_t              state_reg, state_next;
    spk_req_t            req_reg;
    spk_cfg_t            cfg;
    logic                tbl_busy;
    logic [ENTRY_W-1:0]  tbl_rd_data;
    logic                s_xfer;
    logic                out_load;
    spk_status_t         calc_status;
    logic [ADDR_W-1:0]   calc_base_sum;
    logic [PROD_W-1:0]   calc_prod;
    logic [BYTES_W-1:0]  calc_bytes;

    logic                m_valid_reg;
    logic [1:0]          status_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [BYTES_W-1:0]  bytes_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !tbl_busy;
    assign s_xfer    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_SUM) && (!m_valid_reg || m_ready);

    spk_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    spk_pop_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_xfer && s_op),
        .wr_addr (s_table_index),
        .wr_data (s_table_entry),
        .rd_en   (s_xfer && !s_op),
        .rd_addr (s_key[NEURON_W +: TABLE_AW]),
        .rd_data (tbl_rd_data),
        .busy    (tbl_busy)
    );

    spk_row_calc u_calc (
        .aclk      (aclk),
        .en        (state_reg == ST_READ),
        .req       (req_reg),
        .entry     (tbl_rd_data),
        .cfg       (cfg),
        .status    (calc_status),
        .base_sum  (calc_base_sum),
        .prod      (calc_prod),
        .row_bytes (calc_bytes)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_xfer)   state_next = ST_READ;
            ST_READ:               state_next = ST_SUM;
            ST_SUM:  if (out_load) state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg.lookup       <= !s_op;
            req_reg.out_of_range <= (s_key[KEY_W-1:NEURON_W+TABLE_AW] != '0);
            req_reg.neuron       <= s_key[NEURON_W-1:0];
        end
        if (out_load) begin
            status_reg <= calc_status;
            addr_reg   <= calc_base_sum + {{(ADDR_W-PROD_W){1'b0}}, calc_prod};
            bytes_reg  <= calc_bytes;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_row_address = addr_reg;
    assign m_row_bytes   = bytes_reg;

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_busy |-> !s_ready)
        else $error("input taken during table clear");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && (state_reg == ST_READ))
        else $error("second item entered while one is in flight");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> (m_row_address == '0) && (m_row_bytes == '0))
        else $error("failed lookup carries nonzero payload");

endmodule
